// ===== rtl/assert_macros.svh =====
// Assertion helpers used by quintic_trajectory_coefficients.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define QTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qtc assertion failed");

// antecedent implies consequent in the same cycle
`define QTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qtc implication failed");

`endif

// ===== rtl/qtc_pkg.sv =====
// ---------------------------------------------------------------------------
// qtc_pkg
// Widths and constants for the quintic trajectory coefficient pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package qtc_pkg;

    localparam int IN_W      = 48;
    localparam int Q_W       = 64;              // coef3..5 width, quotient bits
    localparam int NUM_W     = 72;              // signed numerator width
    localparam int FRAC_SH   = 16;              // Q16.32 -> Q16.48
    localparam int MAG_W     = NUM_W + FRAC_SH;
    localparam int DEN_W     = 41;              // 2*T^5 fits for T <= 255
    localparam int DIV_LAT   = Q_W + 2;         // abs stage, bit stages, output
    localparam int LINE_LEN  = DIV_LAT + 4;

    localparam logic [7:0] HORIZON_MIN   = 8'd8;
    localparam logic [7:0] HORIZON_RESET = 8'd50;

    localparam logic [Q_W-1:0] COEF_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] COEF_MIN = {1'b1, {(Q_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/qtc_div.sv =====
// ---------------------------------------------------------------------------
// qtc_div
// Pipelined signed divide of (num * 2^16) by den, one quotient bit per
// stage, truncation toward zero and saturation to 64 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module qtc_div
    import qtc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output logic                         out_valid,
    output logic             [Q_W-1:0]   quot,
    output logic                         sat
);

    logic [DEN_W-1:0] rem_reg [0:Q_W];
    logic [Q_W-1:0]   low_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic             v_reg   [0:Q_W];

    logic             neg_next;
    logic [NUM_W-1:0] abs_next;
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-Q_W-1:0] hi_next;
    logic             ovf_next;

    always_comb
    begin
        neg_next = num[NUM_W-1];
        abs_next = neg_next ? NUM_W'(-num) : NUM_W'(num);
        mag_next = {abs_next, {FRAC_SH{1'b0}}};
        hi_next  = mag_next[MAG_W-1:Q_W];
        // quotient >= 2^64 when the top part already reaches the divisor
        ovf_next = DEN_W'(hi_next) >= den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ovf_next ? '0 : DEN_W'(hi_next);
        low_reg[0] <= mag_next[Q_W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= neg_next;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i], low_reg[i][Q_W-1]};
            diff     = trial - {1'b0, den_reg[i]};
            ge       = trial >= {1'b0, den_reg[i]};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            low_reg[i+1] <= {low_reg[i][Q_W-2:0], 1'b0};
            q_reg[i+1]   <= {q_reg[i][Q_W-2:0], ge};
            den_reg[i+1] <= den_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            ovf_reg[i+1] <= ovf_reg[i];
        end
    end

    logic [Q_W-1:0] qf;
    logic           of_next;
    logic [Q_W-1:0] quot_next;
    logic           valid_reg;
    logic [Q_W-1:0] quot_reg;
    logic           sat_reg;

    always_comb
    begin
        qf      = q_reg[Q_W];
        of_next = ovf_reg[Q_W] || (neg_reg[Q_W] ? (qf > COEF_MIN) : qf[Q_W-1]);
        if (of_next)
        begin
            quot_next = neg_reg[Q_W] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            quot_next = neg_reg[Q_W] ? Q_W'(-qf) : qf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= v_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        sat_reg  <= of_next;
    end

    assign out_valid = valid_reg;
    assign quot      = quot_reg;
    assign sat       = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/quintic_trajectory_coefficients.sv =====
// Throughput: one word per cycle; busy stays low, start may be high every cycle.
// The depth is set by the three 64-stage bit-per-cycle dividers by 2*T^3..2*T^5.
// rst_n clears all valid bits and loads horizon_reg with 50; T below 8 acts as 8.
// ---------------------------------------------------------------------------
// quintic_trajectory_coefficients
// Minimum-jerk quintic coefficients from start and end states over T steps.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quintic_trajectory_coefficients
    import qtc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 horizon_we,
    input  wire logic [7:0]           horizon_wdata,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [IN_W-1:0] start_pos,
    input  wire logic signed [IN_W-1:0] start_vel,
    input  wire logic signed [IN_W-1:0] start_acc,
    input  wire logic signed [IN_W-1:0] end_pos,
    input  wire logic signed [IN_W-1:0] end_vel,
    input  wire logic signed [IN_W-1:0] end_acc,
    output logic                      done,
    output logic signed [IN_W-1:0]    coef0,
    output logic signed [IN_W-1:0]    coef1,
    output logic signed [IN_W-1:0]    coef2,
    output logic signed [Q_W-1:0]     coef3,
    output logic signed [Q_W-1:0]     coef4,
    output logic signed [Q_W-1:0]     coef5,
    output logic                      saturated
);

    logic [7:0] horizon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= HORIZON_RESET;
        end
        else if (horizon_we)
        begin
            horizon_reg <= horizon_wdata;
        end
    end

    assign busy = 1'b0;

    // stage 0: capture
    logic                   v0_reg;
    logic signed [IN_W-1:0] sp0_reg, sv0_reg, sa0_reg, ep0_reg, ev0_reg, ea0_reg;
    logic [7:0]             t0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        sp0_reg <= start_pos;
        sv0_reg <= start_vel;
        sa0_reg <= start_acc;
        ep0_reg <= end_pos;
        ev0_reg <= end_vel;
        ea0_reg <= end_acc;
        t0_reg  <= (horizon_reg < HORIZON_MIN) ? HORIZON_MIN : horizon_reg;
    end

    // stage 1: differences and products by T
    logic                 v1_reg;
    logic [7:0]           t1_reg;
    logic [15:0]          t2_1_reg;
    logic signed [IN_W-1:0] sa1_reg;
    logic signed [IN_W:0] epsp1_reg, evsv1_reg, b2_1_reg;
    logic signed [56:0]   svt1_reg, sat1_reg;
    logic signed [IN_W-1:0] sa_adj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= t0_reg;
        t2_1_reg  <= 16'(t0_reg) * 16'(t0_reg);
        sa1_reg   <= sa0_reg;
        epsp1_reg <= (IN_W+1)'(ep0_reg) - (IN_W+1)'(sp0_reg);
        evsv1_reg <= (IN_W+1)'(ev0_reg) - (IN_W+1)'(sv0_reg);
        b2_1_reg  <= (IN_W+1)'(ea0_reg) - (IN_W+1)'(sa0_reg);
        svt1_reg  <= 57'(sv0_reg) * 57'($signed({1'b0, t0_reg}));
        sat1_reg  <= 57'(sa0_reg) * 57'($signed({1'b0, t0_reg}));
    end

    // start_acc / 2 toward zero
    assign sa_adj = sa0_reg + $signed({{(IN_W-1){1'b0}}, sa0_reg[IN_W-1]});

    // stage 2
    logic                 v2_reg;
    logic [7:0]           t2r_reg;
    logic [15:0]          t2_2_reg;
    logic [23:0]          t3_2_reg;
    logic signed [57:0]   b1_2_reg;
    logic signed [64:0]   sat2_2_reg;
    logic signed [59:0]   bbp2_reg;
    logic signed [IN_W:0] b2_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t2r_reg    <= t1_reg;
        t2_2_reg   <= t2_1_reg;
        t3_2_reg   <= 24'(t2_1_reg) * 24'(t1_reg);
        b1_2_reg   <= 58'(evsv1_reg) - 58'(sat1_reg);
        sat2_2_reg <= 65'(sa1_reg) * 65'($signed({1'b0, t2_1_reg}));
        bbp2_reg   <= (60'(epsp1_reg) - 60'(svt1_reg)) <<< 1;
        b2_2_reg   <= b2_1_reg;
    end

    // stage 3: 2*b0, b1*T, b2*T^2
    logic               v3_reg;
    logic [7:0]         t3r_reg;
    logic [23:0]        t3_3_reg;
    logic [31:0]        t4_3_reg;
    logic signed [65:0] bb0_3_reg;
    logic signed [66:0] mb1t_3_reg;
    logic signed [65:0] mb2t2_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t3r_reg     <= t2r_reg;
        t3_3_reg    <= t3_2_reg;
        t4_3_reg    <= 32'(t3_2_reg) * 32'(t2r_reg);
        bb0_3_reg   <= 66'(bbp2_reg) - 66'(sat2_2_reg);
        mb1t_3_reg  <= 67'(b1_2_reg) * 67'($signed({1'b0, t2r_reg}));
        mb2t2_3_reg <= 66'(b2_2_reg) * 66'($signed({1'b0, t2_2_reg}));
    end

    // stage 4: numerators, all scaled by 2 so each divisor is 2*T^k
    logic                    v4_reg;
    logic signed [NUM_W-1:0] n3_reg, n4_reg, n5_reg;
    logic [DEN_W-1:0]        d3_reg, d4_reg, d5_reg;
    logic signed [NUM_W-1:0] bb0_x, b1t_x, b2t2_x;
    logic [39:0]             t5_next;

    always_comb
    begin
        bb0_x   = NUM_W'(bb0_3_reg);
        b1t_x   = NUM_W'(mb1t_3_reg);
        b2t2_x  = NUM_W'(mb2t2_3_reg);
        t5_next = 40'(t4_3_reg) * 40'(t3r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n3_reg <= (bb0_x <<< 3) + (bb0_x <<< 1) - (b1t_x <<< 3) + b2t2_x;
        n4_reg <= (b1t_x <<< 4) - (b1t_x <<< 1) - (bb0_x <<< 4) + bb0_x
                  - (b2t2_x <<< 1);
        n5_reg <= (bb0_x <<< 2) + (bb0_x <<< 1) - (b1t_x <<< 2) - (b1t_x <<< 1)
                  + b2t2_x;
        d3_reg <= DEN_W'({t3_3_reg, 1'b0});
        d4_reg <= DEN_W'({t4_3_reg, 1'b0});
        d5_reg <= DEN_W'({t5_next, 1'b0});
    end

    // pass-through coefficients ride a delay line matched to the dividers
    logic [IN_W-1:0] c0_line [0:LINE_LEN-1];
    logic [IN_W-1:0] c1_line [0:LINE_LEN-1];
    logic [IN_W-1:0] c2_line [0:LINE_LEN-1];

    always_ff @(posedge clk)
    begin
        c0_line[0] <= sp0_reg;
        c1_line[0] <= sv0_reg;
        c2_line[0] <= sa_adj >>> 1;
        for (int k = 1; k < LINE_LEN; k++)
        begin
            c0_line[k] <= c0_line[k-1];
            c1_line[k] <= c1_line[k-1];
            c2_line[k] <= c2_line[k-1];
        end
    end

    logic           dv3, dv4, dv5;
    logic [Q_W-1:0] q3, q4, q5;
    logic           s3, s4, s5;

    qtc_div u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (n3_reg),
        .den       (d3_reg),
        .out_valid (dv3),
        .quot      (q3),
        .sat       (s3)
    );

    qtc_div u_div4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (n4_reg),
        .den       (d4_reg),
        .out_valid (dv4),
        .quot      (q4),
        .sat       (s4)
    );

    qtc_div u_div5 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (n5_reg),
        .den       (d5_reg),
        .out_valid (dv5),
        .quot      (q5),
        .sat       (s5)
    );

    assign done      = dv3;
    assign coef0     = $signed(c0_line[LINE_LEN-1]);
    assign coef1     = $signed(c1_line[LINE_LEN-1]);
    assign coef2     = $signed(c2_line[LINE_LEN-1]);
    assign coef3     = $signed(q3);
    assign coef4     = $signed(q4);
    assign coef5     = $signed(q5);
    assign saturated = s3 || s4 || s5;

    `QTC_ASSERT(a_div_lanes_aligned, (dv3 == dv4) && (dv4 == dv5))
    `QTC_ASSERT_IMP(a_done_from_stage4, done, $past(v4_reg, DIV_LAT))
    `QTC_ASSERT_IMP(a_sat_clips, done && saturated,
        q3 == COEF_MAX || q3 == COEF_MIN || q4 == COEF_MAX || q4 == COEF_MIN ||
        q5 == COEF_MAX || q5 == COEF_MIN)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the quintic coefficient block against a wide-integer predictor.
// Directed and random start/end states are fed over several horizon settings,
// with random or no gaps between words; each done word is checked field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import qtc_pkg::*;

    typedef struct {
        logic signed [IN_W-1:0] c0, c1, c2;
        logic signed [Q_W-1:0]  c3, c4, c5;
        logic                   sat;
    } coef_set_t;

    class coef_scoreboard;
        coef_set_t pending[$];
        int        errors = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // exact quotient of (n * 2^16) / d, truncated toward zero, clipped to 64 bits
        function logic [Q_W-1:0] scaled_quotient(logic signed [159:0] n,
                                                 logic signed [159:0] d, inout logic sat);
            logic signed [159:0] q, hi, lo;
            hi = COEF_MAX;
            lo = -(160'sd1 <<< 63);
            q = (n <<< FRAC_SH) / d;
            if (q > hi) begin
                sat = 1'b1;
                return COEF_MAX;
            end
            if (q < lo) begin
                sat = 1'b1;
                return COEF_MIN;
            end
            return q[Q_W-1:0];
        endfunction

        function void note_input(logic signed [IN_W-1:0] sp, sv, sa, ep, ev, ea,
                                 logic [7:0] t_reg);
            logic signed [159:0] t, p, v, a, xp, xv, xa, bb0, b1, b2, n3, n4, n5, d3;
            logic sat;
            coef_set_t e;
            t = $signed({152'b0, (t_reg < HORIZON_MIN) ? HORIZON_MIN : t_reg});
            p = sp; v = sv; a = sa; xp = ep; xv = ev; xa = ea;
            bb0 = 2 * xp - 2 * p - 2 * t * v - t * t * a;
            b1 = xv - v - t * a;
            b2 = xa - a;
            n3 = 10 * bb0 - 8 * t * b1 + t * t * b2;
            n4 = -15 * bb0 + 14 * t * b1 - 2 * t * t * b2;
            n5 = 6 * bb0 - 6 * t * b1 + t * t * b2;
            d3 = 2 * t * t * t;
            sat = 1'b0;
            e.c0 = sp;
            e.c1 = sv;
            e.c2 = sa / 2;
            e.c3 = scaled_quotient(n3, d3, sat);
            e.c4 = scaled_quotient(n4, d3 * t, sat);
            e.c5 = scaled_quotient(n5, d3 * t * t, sat);
            e.sat = sat;
            pending = {pending, e};
        endfunction

        task check(coef_set_t got);
            coef_set_t e;
            if (pending.size() == 0) begin
                report("done word with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (got.c0 !== e.c0) report($sformatf("coef0 %h exp %h", got.c0, e.c0));
            if (got.c1 !== e.c1) report($sformatf("coef1 %h exp %h", got.c1, e.c1));
            if (got.c2 !== e.c2) report($sformatf("coef2 %h exp %h", got.c2, e.c2));
            if (got.c3 !== e.c3) report($sformatf("coef3 %h exp %h", got.c3, e.c3));
            if (got.c4 !== e.c4) report($sformatf("coef4 %h exp %h", got.c4, e.c4));
            if (got.c5 !== e.c5) report($sformatf("coef5 %h exp %h", got.c5, e.c5));
            if (got.sat !== e.sat) report($sformatf("saturated %b exp %b", got.sat, e.sat));
        endtask
    endclass

    logic clk, rst_n, horizon_we, start, busy, done, saturated;
    logic [7:0] horizon_wdata;
    logic signed [IN_W-1:0] start_pos, start_vel, start_acc, end_pos, end_vel, end_acc;
    logic signed [IN_W-1:0] coef0, coef1, coef2;
    logic signed [Q_W-1:0]  coef3, coef4, coef5;

    coef_scoreboard sb = new();
    logic [7:0] horizon_model;
    int         cycles = 0;
    bit         no_gaps;

    quintic_trajectory_coefficients u_dut (
        .clk(clk), .rst_n(rst_n),
        .horizon_we(horizon_we), .horizon_wdata(horizon_wdata),
        .start(start), .busy(busy),
        .start_pos(start_pos), .start_vel(start_vel), .start_acc(start_acc),
        .end_pos(end_pos), .end_vel(end_vel), .end_acc(end_acc),
        .done(done),
        .coef0(coef0), .coef1(coef1), .coef2(coef2),
        .coef3(coef3), .coef4(coef4), .coef5(coef5),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_model <= HORIZON_RESET;
        end
        else
        begin
            if (horizon_we)
                horizon_model <= horizon_wdata;
            if (start && !busy)
                sb.note_input(start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
                              horizon_model);
            if (done)
                sb.check('{coef0, coef1, coef2, coef3, coef4, coef5, saturated});
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("FAIL quintic_trajectory_coefficients");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] rand_field();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return {1'b0, {(IN_W-1){1'b1}}};
            1: return {1'b1, {(IN_W-1){1'b0}}};
            2, 3: return {{16{r[40]}}, r[31:0]};          // small, around +-1.0
            4: return {{24{r[40]}}, r[23:0]};
            default: return r[IN_W-1:0];
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // called at a falling edge, returns at a falling edge
    task send_word(logic [IN_W-1:0] sp, sv, sa, ep, ev, ea);
        int gap;
        start_pos = sp; start_vel = sv; start_acc = sa;
        end_pos = ep; end_vel = ev; end_acc = ea;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task drain();
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task write_horizon(logic [7:0] t);
        drain();
        horizon_we = 1'b1;
        horizon_wdata = t;
        @(negedge clk);
        horizon_we = 1'b0;
        horizon_wdata = 8'($urandom);
        @(negedge clk);
    endtask

    task random_words(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_word(rand_field(), rand_field(), rand_field(),
                      rand_field(), rand_field(), rand_field());
        end
        no_gaps = 1'b0;
    endtask

    task directed_words();
        logic [IN_W-1:0] mx, mn, one;
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        one = 48'h1_0000_0000;
        send_word(0, 0, 0, 0, 0, 0);
        send_word(mx, mx, mx, mx, mx, mx);
        send_word(mn, mn, mn, mn, mn, mn);
        send_word(mn, mn, mn, mx, mx, mx);     // positive overflow
        send_word(mx, mx, mx, mn, mn, mn);     // negative overflow
        send_word(0, 0, 0, one, 0, 0);
        send_word(0, 0, -48'sd3, 0, 0, 0);     // odd negative acceleration halves toward zero
        send_word(0, 0, 48'sd3, 0, 0, 0);
        send_word(0, 0, 0, -one, 0, 0);
        send_word(0, one, 0, 0, -one, 0);
        send_word(0, 0, 0, 0, 0, one);
        send_word(-48'sd1, -48'sd1, -48'sd1, -48'sd1, -48'sd1, -48'sd1);
        send_word(48'sd1, 48'sd1, 48'sd1, 48'sd1, 48'sd1, 48'sd1);
        send_word(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                  48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        send_word(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                  48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    endtask

    initial
    begin
        no_gaps = 1'b0;
        rst_n = 1'b0;
        horizon_we = 1'b0;
        horizon_wdata = 8'd0;
        start = 1'b0;
        start_pos = 0; start_vel = 0; start_acc = 0;
        end_pos = 0; end_vel = 0; end_acc = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_words();                      // reset horizon
        random_words(200);
        write_horizon(8'd8);
        directed_words();
        random_words(200);
        write_horizon(8'd255);
        directed_words();
        random_words(200);
        write_horizon(8'd0);                   // below range, acts as minimum
        random_words(120);
        write_horizon(8'd7);
        random_words(120);
        write_horizon(8'd9);
        random_words(150);
        write_horizon(8'd100);
        random_words(150);
        for (int k = 0; k < 3; k++)
        begin
            write_horizon(8'($urandom_range(0, 255)));
            random_words(100);
        end
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS quintic_trajectory_coefficients");
        else
            $display("FAIL quintic_trajectory_coefficients");
        $finish;
    end

endmodule

`default_nettype wire
